### hdl/ggnh_pkg.sv
// Shared types and constants for the greedy geographic next-hop block.
// No dependencies.
package ggnh_pkg;

  typedef enum logic [2:0] {
    ACT_DELIVER    = 3'd0,
    ACT_DROP_SELF  = 3'd1,
    ACT_DROP_TTL   = 3'd2,
    ACT_DROP_LOCAL = 3'd3,
    ACT_FORWARD    = 3'd4,
    ACT_UPDATED    = 3'd5,
    ACT_ADDED      = 3'd6,
    ACT_FULL       = 3'd7
  } action_t;

  localparam logic [1:0] CFG_OWN_ADDR = 2'd0;
  localparam logic [1:0] CFG_OWN_X    = 2'd1;
  localparam logic [1:0] CFG_OWN_Y    = 2'd2;

  localparam int TTL_BITS = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_t;

endpackage

### hdl/ggnh_front.sv
// Front end: accepts input beats, settles the self/ttl cases at once and
// queues each item for the back end in a small FIFO. Uses ggnh_pkg.
module ggnh_front #(
  parameter int ADDR_BITS  = 16,
  parameter int COORD_BITS = 16,
  parameter int QW         = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [ADDR_BITS-1:0]          dest_addr,
  input  logic [ggnh_pkg::TTL_BITS-1:0] ttl_in,
  input  logic                          direction_up,
  input  logic [ADDR_BITS-1:0]          own_addr,
  input  logic [QW-1:0]                 rest_in,
  // Queue entry: {rest, pre_done, pre_act, ttl, kind}
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [QW+13-1:0]              q_data
);
  import ggnh_pkg::*;

  localparam int EW = QW + 13;
  logic [EW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;
  logic          pre_done;
  action_t       pre_act;

  always_comb begin
    pre_done = 1'b0;
    pre_act  = ACT_DROP_LOCAL;
    if (kind && dest_addr == own_addr) begin
      pre_done = 1'b1;
      pre_act  = direction_up ? ACT_DELIVER : ACT_DROP_SELF;
    end else if (kind && ttl_in == '0) begin
      pre_done = 1'b1;
      pre_act  = ACT_DROP_TTL;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {rest_in, pre_done, pre_act, ttl_in, kind};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hdl/ggnh_back.sv
// Back end: scans the neighbor table one entry per cycle for updates and
// route lookups and holds the result in an output register. Uses ggnh_pkg.
module ggnh_back #(
  parameter int MAX_NEIGHBORS = 32,
  parameter int ADDR_BITS     = 16,
  parameter int COORD_BITS    = 16,
  parameter int QW            = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [QW+13-1:0]      q_data,
  input  logic [COORD_BITS-1:0] own_x,
  input  logic [COORD_BITS-1:0] own_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ggnh_pkg::action_t     out_action,
  output logic [ADDR_BITS-1:0]  out_hop,
  output logic [7:0]            out_ttl
);
  import ggnh_pkg::*;

  localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam int DW = 2 * COORD_BITS + 1;

  // Memory for entries; valid entries are always the first fill_r slots.
  logic [ADDR_BITS-1:0]  e_addr_m [MAX_NEIGHBORS];
  logic [COORD_BITS-1:0] e_x_m    [MAX_NEIGHBORS];
  logic [COORD_BITS-1:0] e_y_m    [MAX_NEIGHBORS];
  logic [ADDR_BITS-1:0]  rd_addr_r;
  logic [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic [CW-1:0]         fill_r;

  scan_state_t state_r, state_nxt;
  logic [CW-1:0] idx_r;          // entry being read
  logic          rdv_r;          // read data valid
  logic          stop_r;
  logic [DW-1:0] best_r;
  logic [ADDR_BITS-1:0] hop_r;
  logic          found_r;
  logic [IW-1:0] hit_idx_r;
  logic          hit_r;

  logic [QW+13-1:0] item_r;
  logic                  kind;
  logic [7:0]            ttl;
  action_t               pre_act;
  logic                  pre_done;
  logic [ADDR_BITS-1:0]  daddr, naddr;
  logic [COORD_BITS-1:0] dx, dy, nx, ny;

  assign kind     = item_r[0];
  assign ttl      = item_r[8:1];
  assign pre_act  = action_t'(item_r[11:9]);
  assign pre_done = item_r[12];
  assign {ny, nx, naddr, dy, dx, daddr} = item_r[QW+13-1:13];

  // Distance pipeline stage: squares registered, then summed and compared.
  logic [COORD_BITS-1:0] adx, ady;
  logic [2*COORD_BITS-1:0] sqx_r, sqy_r;
  logic                  sqv_r;
  logic [ADDR_BITS-1:0]  sq_addr_r;
  logic [DW-1:0]         dsum;
  logic [COORD_BITS-1:0] ox_abs, oy_abs;

  always_comb begin
    adx = (dx > rd_x_r) ? dx - rd_x_r : rd_x_r - dx;
    ady = (dy > rd_y_r) ? dy - rd_y_r : rd_y_r - dy;
    ox_abs = (dx > own_x) ? dx - own_x : own_x - dx;
    oy_abs = (dy > own_y) ? dy - own_y : own_y - dy;
    dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  logic start, last_rd, busy_done;
  logic init_r;     // computing own distance
  logic best_ld_r;  // own distance is in the sum this cycle
  assign q_ready = (state_r == ST_IDLE) && !out_valid;
  assign start   = q_valid && q_ready;
  assign last_rd = (idx_r == fill_r) || stop_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (last_rd && !rdv_r && !sqv_r && !init_r && !best_ld_r) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
  assign busy_done = (state_r == ST_DONE);

  always_ff @(posedge clk) begin
    if (start) item_r <= q_data;
    rd_addr_r <= e_addr_m[idx_r[IW-1:0]];
    rd_x_r    <= e_x_m[idx_r[IW-1:0]];
    rd_y_r    <= e_y_m[idx_r[IW-1:0]];
    if (init_r) begin
      sqx_r <= ox_abs * ox_abs;
      sqy_r <= oy_abs * oy_abs;
    end else begin
      sqx_r <= adx * adx;
      sqy_r <= ady * ady;
    end
    sq_addr_r <= rd_addr_r;
    if (busy_done && !kind && !hit_r && fill_r != CW'(MAX_NEIGHBORS)) begin
      e_addr_m[fill_r[IW-1:0]] <= naddr;
      e_x_m[fill_r[IW-1:0]]    <= nx;
      e_y_m[fill_r[IW-1:0]]    <= ny;
    end else if (busy_done && !kind && hit_r) begin
      e_x_m[hit_idx_r] <= nx;
      e_y_m[hit_idx_r] <= ny;
    end
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      idx_r     <= '0;
      rdv_r     <= 1'b0;
      sqv_r     <= 1'b0;
      stop_r    <= 1'b0;
      init_r    <= 1'b0;
      best_ld_r <= 1'b0;
      out_valid <= 1'b0;
      hit_r     <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (start) begin
        idx_r     <= '0;
        rdv_r     <= 1'b0;
        sqv_r     <= 1'b0;
        stop_r    <= q_data[12];
        init_r    <= !q_data[12] && q_data[0];
        best_ld_r <= 1'b0;
        hit_r     <= 1'b0;
        found_r   <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        init_r    <= 1'b0;
        best_ld_r <= init_r;
        rdv_r <= !last_rd;
        if (!last_rd) idx_r <= idx_r + 1'b1;
        sqv_r <= rdv_r && !stop_r && kind;
        if (rdv_r && !stop_r && !kind && rd_addr_r == naddr) begin
          hit_r <= 1'b1; hit_idx_r <= IW'(idx_r - 1'b1); stop_r <= 1'b1;
        end
        // A destination match wins over a distance result of an earlier entry.
        if (rdv_r && !stop_r && kind && rd_addr_r == daddr) begin
          hop_r <= rd_addr_r; found_r <= 1'b1; stop_r <= 1'b1;
        end else if (best_ld_r) begin
          best_r <= dsum;
        end else if (sqv_r && !stop_r && dsum < best_r) begin
          best_r <= dsum; hop_r <= sq_addr_r; found_r <= 1'b1;
        end
      end else if (busy_done) begin
        out_valid <= 1'b1;
        out_ttl   <= ttl;
        out_hop   <= '0;
        if (pre_done) out_action <= pre_act;
        else if (!kind) begin
          if (hit_r) out_action <= ACT_UPDATED;
          else if (fill_r == CW'(MAX_NEIGHBORS)) out_action <= ACT_FULL;
          else begin
            out_action <= ACT_ADDED;
            fill_r     <= fill_r + 1'b1;
          end
        end else if (found_r) begin
          out_action <= ACT_FORWARD;
          out_hop    <= hop_r;
          out_ttl    <= ttl - 8'd1;
        end else out_action <= ACT_DROP_LOCAL;
      end
    end
  end
endmodule

### hdl/greedy_geo_next_hop_core.sv
// Greedy geographic next-hop core: top level joining front end and back end.
// The scan reads one entry per cycle and waits for the result beat to leave
// before it takes the next beat from the queue.
// Reset (rst_n, synchronous, active low) empties the table and the queue and
// clears own address and coordinates to zero.
module greedy_geo_next_hop_core #(
  parameter int MAX_NEIGHBORS = 32,
  parameter int COORD_BITS    = 16,
  parameter int ADDR_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: dest_addr, dest_x, dest_y, ttl_in, direction_up,
  // nbr_addr_in, nbr_x_in, nbr_y_in, zero fill
  input  logic [111:0] in_tdata,
  // tuser: kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: next_hop, ttl_out
  output logic [23:0] out_tdata,
  // tuser: action
  output logic [2:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ggnh_pkg::*;

  // Queue payload carries the address and coordinate fields to the back end.
  localparam int QW = 3 * ADDR_BITS - ADDR_BITS + 2 * ADDR_BITS + 4 * COORD_BITS
                      - 2 * ADDR_BITS;

  logic [15:0] own_addr_r, own_x_r, own_y_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      own_x_r    <= '0;
      own_y_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ADDR: own_addr_r <= cfg_data;
        CFG_OWN_X:    own_x_r    <= cfg_data;
        CFG_OWN_Y:    own_y_r    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Fields cut to the configured widths.
  logic [QW-1:0] rest;
  assign rest = {in_tdata[89+COORD_BITS-1:89], in_tdata[73+COORD_BITS-1:73],
                 in_tdata[57+ADDR_BITS-1:57], in_tdata[32+COORD_BITS-1:32],
                 in_tdata[16+COORD_BITS-1:16], in_tdata[ADDR_BITS-1:0]};

  logic              q_valid, q_ready;
  logic [QW+13-1:0]  q_data;

  ggnh_front #(.ADDR_BITS(ADDR_BITS), .COORD_BITS(COORD_BITS), .QW(QW)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .kind(in_tuser), .dest_addr(in_tdata[ADDR_BITS-1:0]),
    .ttl_in(in_tdata[55:48]), .direction_up(in_tdata[56]),
    .own_addr(own_addr_r[ADDR_BITS-1:0]), .rest_in(rest),
    .q_valid, .q_ready, .q_data
  );

  action_t              act;
  logic [ADDR_BITS-1:0] hop;
  logic [7:0]           ttl_o;

  ggnh_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .ADDR_BITS(ADDR_BITS),
              .COORD_BITS(COORD_BITS), .QW(QW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .own_x(own_x_r[COORD_BITS-1:0]), .own_y(own_y_r[COORD_BITS-1:0]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_action(act), .out_hop(hop), .out_ttl(ttl_o)
  );

  assign out_tuser = act;
  assign out_tdata = {ttl_o, 16'(hop)};
endmodule
